// ===== rtl/sha1_pkg.sv =====
// SHA-1 engine package: transfer item types, sequencer states, constants and round functions.
// Stands alone. Used by sha1_hash_engine.
package sha1_pkg;

  localparam int NUM_WORDS = 5;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [2:0] LAST_INDEX = 3'd4;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [NUM_WORDS-1:0][31:0] INIT_VEC = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  function automatic logic [1:0] round_phase(input logic [6:0] r);
    logic [1:0] p;
    if (r < 7'd20) begin
      p = 2'd0;
    end else if (r < 7'd40) begin
      p = 2'd1;
    end else if (r < 7'd60) begin
      p = 2'd2;
    end else begin
      p = 2'd3;
    end
    return p;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] p, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (p)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 hash engine: byte intake, padding sequencer and one shared compression round.
// Depends on sha1_pkg.
//
//   channel  valid      stall      payload                   transfer
//   input    in_valid   in_stall   in_data  (in_item_t)      one byte, end mark
//   output   out_valid  out_stall  out_data (out_item_t)     one digest word
//
// Byte items are taken while idle; the item that completes a 64-byte block then
// runs 80 rounds through the single round unit and the chaining add. End of message
// feeds 9 to 72 padding bytes at one a cycle, pausing during compression, runs one
// or two blocks, then offers five digest words. Input is stalled from end of message
// until the fifth word transfers. Reset is synchronous and needs no clearing pass.
module sha1_hash_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha1_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha1_pkg::out_item_t out_data
);

  sha1_pkg::state_t state;
  sha1_pkg::state_t state_next;

  logic [31:0]  h [sha1_pkg::NUM_WORDS];
  logic [511:0] blk;
  logic [31:0]  a;
  logic [31:0]  b;
  logic [31:0]  c;
  logic [31:0]  d;
  logic [31:0]  e;
  logic [5:0]   fill;
  logic [60:0]  byte_count;
  logic [6:0]   round_cnt;
  logic [2:0]   word_idx;
  logic         pad_active;
  logic         mark_sent;
  logic         len_phase;
  logic         pad_done;

  logic             in_xfer;
  logic             out_xfer;
  logic             put_en;
  logic [7:0]       put_byte;
  logic             block_full;
  logic             len_now;
  logic [7:0][7:0]  len_bytes;
  logic [1:0]       phase;
  logic [31:0]      f_val;
  logic [31:0]      w_mix;
  logic [31:0]      w_new;
  logic [31:0]      temp;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign len_now   = mark_sent && (len_phase || fill == sha1_pkg::LEN_START);
  assign len_bytes = {byte_count, 3'b000};

  always_comb begin
    put_en   = 1'b0;
    put_byte = in_data.data_byte;
    case (state)
      sha1_pkg::ST_IDLE: begin
        put_en = in_xfer && in_data.has_byte;
      end
      sha1_pkg::ST_PAD: begin
        put_en = 1'b1;
        if (!mark_sent) begin
          put_byte = sha1_pkg::PAD_BYTE;
        end else if (len_now) begin
          put_byte = len_bytes[3'd7 - fill[2:0]];
        end else begin
          put_byte = 8'h00;
        end
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  assign block_full = put_en && fill == sha1_pkg::LAST_BYTE;

  assign phase = sha1_pkg::round_phase(round_cnt);
  assign f_val = sha1_pkg::round_f(phase, b, c, d);
  assign w_mix = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign temp  = {a[26:0], a[31:27]} + f_val + e + sha1_pkg::ROUND_K[phase] + blk[511:480];

  always_comb begin
    state_next = state;
    case (state)
      sha1_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (block_full) begin
            state_next = sha1_pkg::ST_ROUND;
          end else if (in_data.end_of_message) begin
            state_next = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        if (fill == sha1_pkg::LAST_BYTE) begin
          state_next = sha1_pkg::ST_ROUND;
        end
      end
      sha1_pkg::ST_ROUND: begin
        if (round_cnt == sha1_pkg::LAST_ROUND) begin
          state_next = sha1_pkg::ST_ADD;
        end
      end
      sha1_pkg::ST_ADD: begin
        if (pad_done) begin
          state_next = sha1_pkg::ST_OUT;
        end else if (pad_active) begin
          state_next = sha1_pkg::ST_PAD;
        end else begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_xfer && word_idx == sha1_pkg::LAST_INDEX) begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall             = 1'b1;
    out_valid            = 1'b0;
    out_data.digest_word = h[word_idx];
    out_data.word_index  = word_idx;
    out_data.last_word   = word_idx == sha1_pkg::LAST_INDEX;
    case (state)
      sha1_pkg::ST_IDLE: in_stall  = 1'b0;
      sha1_pkg::ST_OUT:  out_valid = 1'b1;
      default:           in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1_pkg::ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      round_cnt  <= '0;
      word_idx   <= '0;
      pad_active <= 1'b0;
      mark_sent  <= 1'b0;
      len_phase  <= 1'b0;
      pad_done   <= 1'b0;
      for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
        h[i] <= sha1_pkg::INIT_VEC[i];
      end
    end else begin
      state <= state_next;
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      if (state == sha1_pkg::ST_IDLE && in_xfer) begin
        if (in_data.has_byte) begin
          byte_count <= byte_count + 61'd1;
        end
        if (in_data.end_of_message) begin
          pad_active <= 1'b1;
        end
      end
      if (state == sha1_pkg::ST_PAD) begin
        mark_sent <= 1'b1;
        if (len_now) begin
          len_phase <= 1'b1;
          if (fill == sha1_pkg::LAST_BYTE) begin
            pad_done <= 1'b1;
          end
        end
      end
      if (state == sha1_pkg::ST_ROUND) begin
        round_cnt <= (round_cnt == sha1_pkg::LAST_ROUND) ? 7'd0 : round_cnt + 7'd1;
      end
      if (state == sha1_pkg::ST_ADD) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (state == sha1_pkg::ST_OUT && out_xfer) begin
        if (word_idx == sha1_pkg::LAST_INDEX) begin
          word_idx   <= '0;
          byte_count <= '0;
          pad_active <= 1'b0;
          mark_sent  <= 1'b0;
          len_phase  <= 1'b0;
          pad_done   <= 1'b0;
          for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
            h[i] <= sha1_pkg::INIT_VEC[i];
          end
        end else begin
          word_idx <= word_idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      blk <= {blk[503:0], put_byte};
    end else if (state == sha1_pkg::ST_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
    if (block_full) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (state == sha1_pkg::ST_ROUND) begin
      a <= temp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while digest words are pending");

  a_round_empty_block: assert property (@(posedge clk) disable iff (rst)
    state == sha1_pkg::ST_ROUND |-> fill == 6'd0)
    else $error("byte fill not cleared during compression");

  a_full_block_compress: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.has_byte && fill == sha1_pkg::LAST_BYTE)
      |=> state == sha1_pkg::ST_ROUND)
    else $error("full block did not start compression");

  a_restart_after_digest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_word)
      |=> (state == sha1_pkg::ST_IDLE && byte_count == 61'd0 &&
           h[0] == sha1_pkg::INIT_VEC[0] && !pad_active))
    else $error("state not restored after final digest word");
`endif

endmodule

// ===== sim/sha1_checker.sv =====
// Scoreboard for the SHA-1 engine: watches both transfer channels, predicts the digest
// words from the accepted bytes and compares each word as it leaves the block.
// Depends on sha1_pkg; instantiated by tb beside sha1_hash_engine.
module sha1_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sha1_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sha1_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);

  logic [31:0]         chain_words [sha1_pkg::NUM_WORDS];
  logic [31:0]         block_buf [16];
  logic [5:0]          block_pos;
  logic [60:0]         msg_bytes;
  sha1_pkg::out_item_t digest_queue [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic restart_message();
    for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
      chain_words[i] = sha1_pkg::INIT_VEC[i];
    end
    block_pos = '0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, w, t;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int i = 0; i < 16; i++) begin
      sched[i] = block_buf[i];
    end
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
      end else if (r >= 40 && r < 60) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      if (r < 16) begin
        w = sched[r];
      end else begin
        w = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
            sched[(r + 2) % 16] ^ sched[r % 16];
        w = {w[30:0], w[31]};
        sched[r % 16] = w;
      end
      t = {a[26:0], a[31:27]} + f + e + sha1_pkg::ROUND_K[r / 20] + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] value);
    logic [31:0] word;
    word = block_buf[block_pos[5:2]];
    word[{~block_pos[1:0], 3'b000} +: 8] = value;
    block_buf[block_pos[5:2]] = word;
    block_pos++;
    if (block_pos == '0) begin
      compress_block();
    end
  endtask

  task automatic finish_message();
    logic [63:0]         bit_len;
    sha1_pkg::out_item_t item;
    bit_len = {msg_bytes, 3'b000};
    absorb_byte(sha1_pkg::PAD_BYTE);
    while (block_pos != sha1_pkg::LEN_START) begin
      absorb_byte(8'h00);
    end
    for (int i = 7; i >= 0; i--) begin
      absorb_byte(bit_len[i * 8 +: 8]);
    end
    for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) begin
      item.digest_word = chain_words[i];
      item.word_index  = 3'(i);
      item.last_word   = (i == sha1_pkg::NUM_WORDS - 1);
      digest_queue = {digest_queue, item};
    end
    restart_message();
  endtask

  always @(posedge clk) begin
    sha1_pkg::out_item_t want;
    if (rst) begin
      restart_message();
      for (int i = 0; i < 16; i++) begin
        block_buf[i] = '0;
      end
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          report_mismatch($sformatf("digest word %h with none expected",
                                    out_data.digest_word));
        end else begin
          want = digest_queue.pop_front();
          if (out_data.digest_word !== want.digest_word) begin
            report_mismatch($sformatf("digest_word got %h expected %h",
                                      out_data.digest_word, want.digest_word));
          end
          if (out_data.word_index !== want.word_index) begin
            report_mismatch($sformatf("word_index got %0d expected %0d",
                                      out_data.word_index, want.word_index));
          end
          if (out_data.last_word !== want.last_word) begin
            report_mismatch($sformatf("last_word got %b expected %b",
                                      out_data.last_word, want.last_word));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.has_byte) begin
          absorb_byte(in_data.data_byte);
          msg_bytes++;
        end
        if (in_data.end_of_message) begin
          finish_message();
        end
      end
    end
    pending = digest_queue.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for sha1_hash_engine: drives message bytes with random gaps and stalls,
// holds the receiver off once to back up the engine, and prints the verdict.
// Depends on sha1_pkg, sha1_hash_engine and sha1_checker.
module tb;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                out_stall = 1'b0;
  sha1_pkg::in_item_t  in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  sha1_pkg::out_item_t out_data;

  int fail_count;
  int pending;
  int words_taken = 0;
  int n_items     = 0;
  int n_msgs      = 0;
  int n_bytes     = 0;
  int n_two_block = 0;
  bit calm        = 1'b0;
  bit held_off    = 1'b0;

  sha1_hash_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sha1_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_taken <= words_taken + 1;
    end
  end

  task automatic send_item(input logic [7:0] value, input logic has, input logic eom);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, has_byte: has, end_of_message: eom};
    do begin
      @(posedge clk);
    end while (in_stall);
    n_items++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end
  endtask

  task automatic send_message(input int len, input bit joined);
    bit join_last;
    join_last = joined && (len > 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b1, join_last && (i == len - 1));
    end
    if (!join_last) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    n_msgs++;
    n_bytes += len;
    if (len % 64 >= 56) begin
      n_two_block++;
    end
  endtask

  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held_off && words_taken >= 10) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        held_off = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int pick;
    int len;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    n_msgs  += 4;
    n_bytes += 6;

    send_message($urandom_range(56, 63), 1'($urandom_range(0, 1)));
    while (n_items < 160) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(0, 12);
      end else if (pick < 9) begin
        len = $urandom_range(50, 66);
      end else begin
        len = $urandom_range(64, 72);
      end
      send_message(len, 1'($urandom_range(0, 1)));
      if (n_items >= 140) begin
        calm = 1'b1;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d messages, %0d message bytes, %0d digest words checked",
             n_msgs, n_bytes, words_taken);
    $display("%0d messages padded into a second block, one long output hold-off",
             n_two_block);
    if (fail_count == 0) begin
      $display("PASS sha1_hash_engine");
    end else begin
      $display("FAIL sha1_hash_engine");
    end
    $finish;
  end

  initial begin
    #3600000;
    $display("timed out with %0d digest words outstanding", pending);
    $display("FAIL sha1_hash_engine");
    $finish;
  end

endmodule
